[rtl/sidcd_pkg.sv]
// Shared types and constants for the sync/ID checksum packet deframer.
// No dependencies; every other file in rtl/ imports this package.
package sidcd_pkg;

  localparam int DEF_PACKET_BYTES = 32;
  localparam int BYTE_W           = 8;
  localparam int CNT_W            = 16;
  localparam int SUM_W            = 16;
  localparam int CFG_IDX_W        = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAV_ID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_ID    = 2'd2;

  // Control from the sequencer to the checksum accumulator.
  typedef struct packed {
    logic clear;
    logic add;
    logic hi_byte;
  } sum_ctrl_t;

endpackage

[rtl/sidcd_cell.sv]
// One byte cell of the receive window chain.
// Depends on sidcd_pkg for the byte width.
module sidcd_cell
  import sidcd_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] din,
  output logic [BYTE_W-1:0] dout
);

  logic [BYTE_W-1:0] q;

  // The cell takes its neighbor's byte whenever the chain moves.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  assign dout = q;

endmodule

[rtl/sidcd_sum.sv]
// Checksum accumulator: adds one byte per cycle, while add is set, into the 16-bit word sum.
// Depends on sidcd_pkg for widths and the control struct.
module sidcd_sum
  import sidcd_pkg::*;
(
  input  logic              clk,
  input  sum_ctrl_t         ctrl,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [SUM_W-1:0]  sum
);

  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] term;

  // Even byte positions are the low half of a word, odd ones the high half.
  assign term = ctrl.hi_byte ? {byte_in, {BYTE_W{1'b0}}} : {{BYTE_W{1'b0}}, byte_in};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= acc + term;
    end
  end

  assign sum = acc;

endmodule

[rtl/sync_id_checksum_packet_deframer.sv]
// Sync/ID packet deframer with a 16-bit little-endian word checksum.
// Once the window is full, each byte is accepted and then given a header test; a sync+nav
// header adds a rotation of the whole window through the checksum adder and a verdict, and
// a good packet then leaves at one byte per cycle while the output is ready.
// Throughput is set by the rotation of the byte chain through the single checksum adder.
// Reset (rst, synchronous, active high) empties the window and clears counters and registers.
module sync_id_checksum_packet_deframer
  import sidcd_pkg::*;
#(
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream. s_tdata: [7:0] rx_byte.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,
  // Output stream. m_tdata: [7:0] data_byte, [23:8] good_count, [39:24] bad_count,
  // [55:40] other_header_count, [71:56] ctrl_header_count. m_tlast: last_byte.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W+4*CNT_W-1:0] m_tdata,
  output logic                 m_tlast,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int STEP_W = $clog2(PACKET_BYTES);
  localparam int FILL_W = $clog2(PACKET_BYTES + 1);

  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(PACKET_BYTES);
  localparam logic [FILL_W-1:0] FILL_SLIDE = FILL_W'(PACKET_BYTES - 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(PACKET_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_FILL  = 3'd0;  // taking bytes into the window
  localparam logic [2:0] S_TEST  = 3'd1;  // header test on a full window
  localparam logic [2:0] S_SUM   = 3'd2;  // rotating the chain through the adder
  localparam logic [2:0] S_CHECK = 3'd3;  // comparing the sum with the trailer
  localparam logic [2:0] S_EMIT  = 3'd4;  // sending the packet out

  logic [2:0]        state, state_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [STEP_W-1:0] step, step_next;

  logic [CNT_W-1:0]  good_total, bad_total, other_total, ctrl_total;
  logic [BYTE_W-1:0] sync_value, nav_id, ctrl_id;

  logic              in_fire, out_fire, chain_shift;
  logic [BYTE_W-1:0] tail_in;
  logic [BYTE_W-1:0] cell_q [PACKET_BYTES];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  rx_sum;
  logic [STEP_W:0]   pair_start;
  sum_ctrl_t         sum_ctrl;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_FILL);
  assign in_fire   = s_tvalid && s_tready;
  assign m_tvalid  = (state == S_EMIT);
  assign out_fire  = m_tvalid && m_tready;

  // The chain moves on every accepted byte, on every rotation step of the checksum pass,
  // and on every byte handed to the output. Once the window is full, the oldest byte sits in cell 0.
  assign chain_shift = in_fire || (state == S_SUM) || out_fire;
  // New bytes enter at the tail; otherwise the head wraps around so the window survives
  // the checksum rotation unchanged.
  assign tail_in = (state == S_FILL) ? s_tdata : cell_q[0];

  for (genvar i = 0; i < PACKET_BYTES; i++) begin : g_cell
    if (i == PACKET_BYTES - 1) begin : g_tail
      sidcd_cell u_cell (.clk(clk), .shift(chain_shift), .din(tail_in), .dout(cell_q[i]));
    end else begin : g_body
      sidcd_cell u_cell (.clk(clk), .shift(chain_shift), .din(cell_q[i+1]), .dout(cell_q[i]));
    end
  end

  // During the rotation, cell 0 holds byte number step. A byte belongs to the sum when its
  // word starts more than two bytes before the end of the packet.
  assign pair_start = {1'b0, step[STEP_W-1:1], 1'b0};

  always_comb begin
    sum_ctrl.clear   = (state == S_TEST);
    sum_ctrl.add     = (state == S_SUM) &&
                       ((pair_start + (STEP_W+1)'(2)) < (STEP_W+1)'(PACKET_BYTES));
    sum_ctrl.hi_byte = step[0];
  end

  sidcd_sum u_sum (
    .clk    (clk),
    .ctrl   (sum_ctrl),
    .byte_in(cell_q[0]),
    .sum    (sum)
  );

  assign rx_sum = {cell_q[PACKET_BYTES-1], cell_q[PACKET_BYTES-2]};

  always_comb begin
    state_next = state;
    fill_next  = fill;
    step_next  = step;
    unique case (state)
      S_FILL: begin
        if (in_fire) begin
          if (fill >= FILL_SLIDE) begin
            fill_next  = FILL_FULL;
            state_next = S_TEST;
          end else begin
            fill_next = fill + FILL_W'(1);
          end
        end
      end
      S_TEST: begin
        step_next = '0;
        if ((cell_q[0] == sync_value) && (cell_q[1] == nav_id)) begin
          state_next = S_SUM;
        end else begin
          // Not a navigation packet: drop the oldest byte and wait for the next one.
          fill_next  = FILL_SLIDE;
          state_next = S_FILL;
        end
      end
      S_SUM: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        step_next = '0;
        if (sum == rx_sum) begin
          state_next = S_EMIT;
        end else begin
          fill_next  = FILL_SLIDE;
          state_next = S_FILL;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          step_next = step + STEP_W'(1);
          if (step == STEP_LAST) begin
            step_next  = '0;
            fill_next  = '0;
            state_next = S_FILL;
          end
        end
      end
      default: begin
        state_next = S_FILL;
        fill_next  = '0;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      step  <= step_next;
    end
  end

  // Packet counters. The header verdict is taken in the test cycle, the checksum verdict
  // in the check cycle, so a result always carries totals that include its own packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      good_total  <= '0;
      bad_total   <= '0;
      other_total <= '0;
      ctrl_total  <= '0;
    end else begin
      if ((state == S_TEST) && (cell_q[0] == sync_value) && (cell_q[1] != nav_id)) begin
        other_total <= other_total + CNT_W'(1);
        if (cell_q[1] == ctrl_id) begin
          ctrl_total <= ctrl_total + CNT_W'(1);
        end
      end
      if (state == S_CHECK) begin
        if (sum == rx_sum) begin
          good_total <= good_total + CNT_W'(1);
        end else begin
          bad_total <= bad_total + CNT_W'(1);
        end
      end
    end
  end

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= '0;
      nav_id     <= '0;
      ctrl_id    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SYNC_VALUE) begin
        sync_value <= cfg_data;
      end
      if (cfg_index == REG_NAV_ID) begin
        nav_id <= cfg_data;
      end
      if (cfg_index == REG_CTRL_ID) begin
        ctrl_id <= cfg_data;
      end
    end
  end

  assign m_tdata = {ctrl_total, other_total, bad_total, good_total, cell_q[0]};
  assign m_tlast = (step == STEP_LAST);

  // The window never holds more than one packet.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("window fill count beyond packet length");

  // The final byte of a packet leaves the window empty.
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_tlast) |=> (fill == '0) && (state == S_FILL))
    else $error("window not emptied after packet");

  // A good packet is counted exactly when its emission begins.
  a_good_on_emit: assert property (@(posedge clk) disable iff (rst)
    (good_total != $past(good_total)) |-> (state == S_EMIT) && (step == '0))
    else $error("good counter moved outside packet start");

  // Emission only follows a full window and a checksum pass.
  a_emit_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_CHECK) && (fill == FILL_FULL))
    else $error("packet emitted without checksum verdict");

endmodule

[tb/tb_sync_id_checksum_packet_deframer.sv]
// Self-checking testbench for sync_id_checksum_packet_deframer: drives a received byte stream,
// predicts every deframed packet byte internally and compares each output transaction.
// Depends on sidcd_pkg and the deframer RTL only.
module tb_sync_id_checksum_packet_deframer;
  import sidcd_pkg::*;

  localparam int PACKET_BYTES = DEF_PACKET_BYTES;
  // Time for the block to finish a header test, a full checksum rotation and its verdict.
  localparam int SETTLE_CYCLES = 3 * PACKET_BYTES;
  localparam int END_WAIT_CYCLES = 20000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // The index field has one code past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [PACKET_BYTES-1:0][7:0] pkt_buf_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_last;
    logic [15:0] good;
    logic [15:0] bad;
    logic [15:0] other;
    logic [15:0] ctrl;
  } deframed_byte_t;

  typedef enum logic [1:0] {ROW_FRAME, ROW_NOISE, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RAND} fill_mode_t;

  // One row of the directed part. For a frame row, a and b are the two header bytes; for a
  // register row, a is the index and b the value; for a noise row, a is the byte count.
  // Typed rows carry the counter values that the emitted packet must show.
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  a;
    logic [7:0]  b;
    fill_mode_t  fill;
    logic        good_sum;
    logic        typed;
    logic [15:0] e_good;
    logic [15:0] e_bad;
    logic [15:0] e_other;
    logic [15:0] e_ctrl;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [BYTE_W+4*CNT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  sync_id_checksum_packet_deframer #(
    .PACKET_BYTES(PACKET_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // [7:0] rx_byte
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // [7:0] data, [23:8] good, [39:24] bad, [55:40] other, [71:56] ctrl
    .m_tlast(m_tlast),     // last byte of the packet
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the sliding byte window, its fill level, the four packet counters and
  // a copy of the three configuration registers.
  pkt_buf_t win_bytes;
  int unsigned win_fill;
  logic [15:0] tot_good, tot_bad, tot_other, tot_ctrl;
  logic [7:0] sync_byte, nav_byte, ctrl_byte;

  // Packet bytes that the block still owes, oldest first.
  deframed_byte_t pending_packet_bytes[$];

  stim_row_t stim_rows[$];
  pkt_buf_t frame_buf;
  bit idle_on = 1'b1;
  int unsigned bytes_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  int stall_left;
  deframed_byte_t got, want;

  // Wrapping sum of little-endian byte pairs over all but the two trailing checksum bytes.
  // With an odd packet size the last pair reaches into the first checksum byte.
  function automatic logic [15:0] pair_sum(input pkt_buf_t bytes);
    logic [15:0] acc;
    int k;
    acc = '0;
    for (k = 0; k + 2 < PACKET_BYTES; k += 2) begin
      acc = acc + {bytes[k+1], bytes[k]};
    end
    return acc;
  endfunction

  function automatic void push_result(input logic [7:0] data, input logic is_last,
                                      input logic [15:0] g, b, o, c);
    pending_packet_bytes.push_back('{data: data, is_last: is_last, good: g, bad: b,
                                     other: o, ctrl: c});
  endfunction

  // Drop the oldest window byte; the window then waits for one more byte before the next test.
  function automatic void slide_window();
    win_bytes = win_bytes >> 8;
    win_fill = PACKET_BYTES - 1;
  endfunction

  // Predicts what one accepted byte does. When emit is clear, the state still advances but the
  // packet bytes are left for the caller to queue from a hand-typed expectation.
  function automatic void deframe_byte(input logic [7:0] b, input bit emit);
    int k;
    win_bytes[win_fill] = b;
    win_fill++;
    if (win_fill < PACKET_BYTES) return;
    if (win_bytes[0] != sync_byte) begin
      slide_window();
      return;
    end
    // Sync seen: a non-navigation ID is an other header, and possibly also a control header.
    // The navigation test comes first, so nav_id equal to ctrl_id never counts as control.
    if (win_bytes[1] != nav_byte) begin
      tot_other++;
      if (win_bytes[1] == ctrl_byte) tot_ctrl++;
      slide_window();
      return;
    end
    if (pair_sum(win_bytes) != {win_bytes[PACKET_BYTES-1], win_bytes[PACKET_BYTES-2]}) begin
      tot_bad++;
      slide_window();
      return;
    end
    tot_good++;
    if (emit) begin
      for (k = 0; k < PACKET_BYTES; k++) begin
        push_result(win_bytes[k], k == PACKET_BYTES - 1, tot_good, tot_bad, tot_other,
                    tot_ctrl);
      end
    end
    win_fill = 0;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [7:0] a, b,
                                  input fill_mode_t fill = FILL_RAND, input bit good_sum = 1'b1,
                                  input bit typed = 1'b0, input logic [15:0] eg = '0,
                                  input logic [15:0] eb = '0, input logic [15:0] eo = '0,
                                  input logic [15:0] ec = '0);
    stim_rows.push_back('{kind: kind, a: a, b: b, fill: fill, good_sum: good_sum,
                          typed: typed, e_good: eg, e_bad: eb, e_other: eo, e_ctrl: ec});
  endfunction

  // Offers one byte, with a random gap in front of it while idling is on, and waits for the
  // transaction. s_tvalid stays high afterwards so back-to-back bytes follow without a pause.
  task automatic send_byte(input logic [7:0] b, input bit emit);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_byte(b, emit);
    bytes_sent++;
  endtask

  // Builds one packet-sized frame with the given header and body, a correct checksum or one
  // with a flipped bit pattern in one of its two bytes, and sends it.
  task automatic send_frame(input logic [7:0] hdr0, hdr1, input fill_mode_t fill,
                            input bit good_sum, input bit emit);
    logic [15:0] sum;
    int k;
    frame_buf = '0;
    frame_buf[0] = hdr0;
    frame_buf[1] = hdr1;
    for (k = 2; k < PACKET_BYTES - 2; k++) begin
      case (fill)
        FILL_ZERO: frame_buf[k] = 8'h00;
        FILL_ONES: frame_buf[k] = 8'hFF;
        FILL_RAMP: frame_buf[k] = 8'(k);
        default:   frame_buf[k] = 8'($urandom_range(0, 255));
      endcase
    end
    sum = pair_sum(frame_buf);
    frame_buf[PACKET_BYTES-2] = sum[7:0];
    frame_buf[PACKET_BYTES-1] = sum[15:8];
    if (!good_sum) begin
      frame_buf[PACKET_BYTES-2+$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    end
    for (k = 0; k < PACKET_BYTES; k++) send_byte(frame_buf[k], emit);
  endtask

  // Stops the input side and waits until every predicted packet byte has come out, then lets
  // the block finish any header test or checksum rotation that produces no output.
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_packet_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SYNC_VALUE: sync_byte = v;
      REG_NAV_ID:     nav_byte = v;
      REG_CTRL_ID:    ctrl_byte = v;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] s, n, c);
    drain(SETTLE_CYCLES);
    write_reg(REG_SYNC_VALUE, s);
    write_reg(REG_NAV_ID, n);
    write_reg(REG_CTRL_ID, c);
  endtask

  // Mostly well-formed frames under the current header setting, so that most traffic gets
  // through the header test into the checksum stage; the rest is broken checksums, foreign or
  // control IDs and short bursts of noise rich in sync bytes.
  task automatic random_phase(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned k;
    fill_mode_t fill;
    logic [7:0] id;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) drain(0);
      pick = $urandom_range(0, 99);
      fill = ($urandom_range(0, 4) == 0) ? fill_mode_t'($urandom_range(0, 2)) : FILL_RAND;
      if (pick < 55) begin
        send_frame(sync_byte, nav_byte, fill, 1'b1, 1'b1);
      end else if (pick < 70) begin
        send_frame(sync_byte, nav_byte, fill, 1'b0, 1'b1);
      end else if (pick < 80) begin
        id = $urandom_range(0, 1) ? ctrl_byte : 8'($urandom_range(0, 255));
        send_frame(sync_byte, id, fill, 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        for (k = $urandom_range(1, 12); k != 0; k--) begin
          send_byte(($urandom_range(0, 3) == 0) ? sync_byte : 8'($urandom_range(0, 255)), 1'b1);
        end
      end
    end
  endtask

  // Output side: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every output transaction is compared with the oldest predicted packet byte.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{data: m_tdata[7:0], is_last: m_tlast, good: m_tdata[23:8],
              bad: m_tdata[39:24], other: m_tdata[55:40], ctrl: m_tdata[71:56]};
      if (pending_packet_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output: data %h last %b good %0d bad %0d other %0d ctrl %0d",
                   got.data, got.is_last, got.good, got.bad, got.other, got.ctrl);
        end
      end else begin
        want = pending_packet_bytes.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected data %h last %b good %0d bad %0d other %0d ctrl %0d",
                     want.data, want.is_last, want.good, want.bad, want.other, want.ctrl);
            $display("          actual   data %h last %b good %0d bad %0d other %0d ctrl %0d",
                     got.data, got.is_last, got.good, got.bad, got.other, got.ctrl);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int k;
    int waited;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    win_bytes = '0;
    win_fill = 0;
    {tot_good, tot_bad, tot_other, tot_ctrl} = '0;
    {sync_byte, nav_byte, ctrl_byte} = '0;

    // Directed part. With every register at its reset value of zero, an all-zero frame is
    // already a valid packet, as is a frame of ones under a zero header.
    add_row(ROW_FRAME, 8'h00, 8'h00, FILL_ZERO, 1'b1, 1'b1, 16'd1, 16'd0, 16'd0, 16'd0);
    add_row(ROW_FRAME, 8'h00, 8'h00, FILL_ONES, 1'b1, 1'b1, 16'd2, 16'd0, 16'd0, 16'd0);
    // Navigation and control IDs equal: the packet counts as navigation, control stays zero.
    add_row(ROW_REG, 8'(REG_SYNC_VALUE), 8'hFF);
    add_row(ROW_REG, 8'(REG_NAV_ID), 8'hFF);
    add_row(ROW_REG, 8'(REG_CTRL_ID), 8'hFF);
    add_row(ROW_FRAME, 8'hFF, 8'hFF, FILL_RAMP, 1'b1, 1'b1, 16'd3, 16'd0, 16'd0, 16'd0);
    // A broken checksum, then a write to the unused index that must change nothing.
    add_row(ROW_FRAME, 8'hFF, 8'hFF, FILL_RAND, 1'b0);
    add_row(ROW_REG, 8'(REG_UNUSED), 8'h5A);
    // A foreign ID, then one that matches the control ID.
    add_row(ROW_FRAME, 8'hFF, 8'h00, FILL_RAND, 1'b1);
    add_row(ROW_REG, 8'(REG_CTRL_ID), 8'h00);
    add_row(ROW_FRAME, 8'hFF, 8'h00, FILL_ZERO, 1'b1);
    add_row(ROW_NOISE, 8'd8, 8'h00);
    add_row(ROW_FRAME, 8'hFF, 8'hFF, FILL_ONES, 1'b1);
    add_row(ROW_REG, 8'(REG_SYNC_VALUE), 8'hA5);
    add_row(ROW_REG, 8'(REG_NAV_ID), 8'h3C);
    add_row(ROW_REG, 8'(REG_CTRL_ID), 8'h5A);
    add_row(ROW_FRAME, 8'hA5, 8'h5A, FILL_RAND, 1'b1);
    add_row(ROW_FRAME, 8'hA5, 8'h3C, FILL_RAND, 1'b1);
    add_row(ROW_FRAME, 8'hA5, 8'h3C, FILL_RAND, 1'b0);
    add_row(ROW_NOISE, 8'd5, 8'h00);
    add_row(ROW_FRAME, 8'hA5, 8'h3C, FILL_ZERO, 1'b1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      case (row.kind)
        ROW_REG: begin
          drain(SETTLE_CYCLES);
          write_reg(row.a[CFG_IDX_W-1:0], row.b);
        end
        ROW_NOISE: begin
          for (k = 0; k < row.a; k++) send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        default: begin
          // Typed rows start on an empty window, so the frame itself is the packet.
          send_frame(row.a, row.b, row.fill, row.good_sum, !row.typed);
          if (row.typed) begin
            for (k = 0; k < PACKET_BYTES; k++) begin
              push_result(frame_buf[k], k == PACKET_BYTES - 1, row.e_good, row.e_bad,
                          row.e_other, row.e_ctrl);
            end
          end
        end
      endcase
    end

    // Random part under three header settings; the second makes sync and navigation equal.
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    random_phase(20);
    k = $urandom_range(0, 255);
    set_regs(8'(k), 8'(k), 8'($urandom_range(0, 255)));
    random_phase(20);
    idle_on = 1'b0;
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    random_phase(20);

    s_tvalid <= 1'b0;
    for (waited = 0; pending_packet_bytes.size() != 0 && waited < END_WAIT_CYCLES; waited++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_packet_bytes.size() != 0) begin
      $display("%0d predicted packet bytes never came out", pending_packet_bytes.size());
    end
    if (mismatches == 0 && pending_packet_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
